FILE: design/ddq_pkg.sv
package ddq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int TAG_BITS    = 16;

    localparam int IDX_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W    = CNT_W + 1;
    localparam int LIMIT_W  = 5;
    localparam int CMP_W    = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
    localparam int TIME_W   = 32;
    localparam int BUDGET_W = 8;
    localparam int WAIT_W   = 16;
    localparam int PTAG_W   = 16;
    localparam int PCNT_W   = 5;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(16);

    localparam logic [1:0] CMD_URGENT = 2'd0;
    localparam logic [1:0] CMD_PLAIN  = 2'd1;
    localparam logic [1:0] CMD_TICK   = 2'd2;

    localparam logic [2:0] EV_ACCEPTED = 3'd0;
    localparam logic [2:0] EV_REFUSED  = 3'd1;
    localparam logic [2:0] EV_EXPIRED  = 3'd2;
    localparam logic [2:0] EV_URGENT   = 3'd3;
    localparam logic [2:0] EV_PLAIN    = 3'd4;
    localparam logic [2:0] EV_IDLE     = 3'd5;

    typedef struct packed {
        logic [1:0]          command;
        logic [PTAG_W-1:0]   entry_tag;
        logic [BUDGET_W-1:0] budget;
    } ddq_in_t;

    typedef struct packed {
        logic [2:0]        event_res;
        logic [PTAG_W-1:0] result_tag;
        logic [WAIT_W-1:0] waited;
        logic [PCNT_W-1:0] urgent_count;
        logic [PCNT_W-1:0] plain_count;
        logic              last;
    } ddq_out_t;

    typedef struct packed {
        logic [TAG_BITS-1:0] tag;
        logic [TIME_W-1:0]   stamp;
        logic [BUDGET_W-1:0] budget;
    } ddq_entry_t;

    typedef struct packed {
        logic [TAG_BITS-1:0] tag;
        logic [TIME_W-1:0]   stamp;
    } ddq_plain_t;

    typedef struct packed {
        logic shift;
        logic load;
    } ddq_cell_ctrl_t;

    typedef struct packed {
        logic              expired;
        logic              rem_one;
        logic [WAIT_W-1:0] waited;
    } ddq_eval_t;

    function automatic logic [TAG_BITS-1:0] tag_in(input logic [PTAG_W-1:0] t);
        logic [TAG_BITS+PTAG_W-1:0] wide;
        wide = {{TAG_BITS{1'b0}}, t};
        return wide[TAG_BITS-1:0];
    endfunction

    function automatic logic [PTAG_W-1:0] tag_out(input logic [TAG_BITS-1:0] t);
        logic [TAG_BITS+PTAG_W-1:0] wide;
        wide = {{PTAG_W{1'b0}}, t};
        return wide[PTAG_W-1:0];
    endfunction

    function automatic logic [WAIT_W-1:0] sat_wait(input logic [TIME_W-1:0] now,
                                                   input logic [TIME_W-1:0] stamp);
        logic [TIME_W-1:0] diff;
        diff = now - stamp;
        if (diff[TIME_W-1:WAIT_W] != '0)
            return {WAIT_W{1'b1}};
        return diff[WAIT_W-1:0];
    endfunction

endpackage

FILE: design/ddq_ram.sv
module ddq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                        clk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic                                        re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/ddq_cell.sv
module ddq_cell (
    input  logic                    clk,
    input  ddq_pkg::ddq_cell_ctrl_t ctrl,
    input  ddq_pkg::ddq_entry_t     load_data,
    input  ddq_pkg::ddq_entry_t     right_data,
    output ddq_pkg::ddq_entry_t     data
);

    ddq_pkg::ddq_entry_t data_reg;
    ddq_pkg::ddq_entry_t data_next;

    // Load wins over shift: the tail slot takes the recirculated entry.
    always_comb
    begin
        data_next = data_reg;
        if (ctrl.load)
        begin
            data_next = load_data;
        end
        else if (ctrl.shift)
        begin
            data_next = right_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

FILE: design/ddq_head_eval.sv
module ddq_head_eval (
    input  ddq_pkg::ddq_entry_t              entry,
    input  logic [ddq_pkg::TIME_W-1:0]       now,
    output ddq_pkg::ddq_eval_t               eval
);

    logic [ddq_pkg::TIME_W-1:0]       elapsed;
    logic                             expired;
    logic [ddq_pkg::BUDGET_W:0]       elapsed_p1;

    assign elapsed    = now - entry.stamp;
    assign expired    = (elapsed[ddq_pkg::TIME_W-1:ddq_pkg::BUDGET_W] != '0) ||
                        (elapsed[ddq_pkg::BUDGET_W-1:0] >= entry.budget);
    assign elapsed_p1 = {1'b0, elapsed[ddq_pkg::BUDGET_W-1:0]} + 1'b1;

    assign eval.expired = expired;
    // Remaining budget of exactly one tick
    assign eval.rem_one = !expired && (elapsed_p1 == {1'b0, entry.budget});
    assign eval.waited  = ddq_pkg::sat_wait(now, entry.stamp);

endmodule

FILE: design/deadline_dual_queue_scheduler.sv
// Two-class scheduler: an urgent queue of entries with a deadline budget, held in a row
// of shift cells with the head at cell 0, and a plain circular queue in a small RAM. A
// request gives one beat (accepted or refused). On a tick the scheduler first takes the
// tick, then walks every urgent entry through the head cell once, one per cycle unless an
// expiry beat waits on a stalled output, emitting an expiry beat for each entry whose
// budget is used up and recirculating the rest to the tail; a closing step then ends the
// walk, and the serve step serves the first survivor with one tick of budget left, else
// the urgent head, else the plain head, else reports idle. The serve beat carries last
// set. Configuration writes of the queue limit are taken at any time and apply to the
// following requests.
module deadline_dual_queue_scheduler (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  ddq_pkg::ddq_in_t                    in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output ddq_pkg::ddq_out_t                   out_data,
    input  logic                                cfg_we,
    input  logic [ddq_pkg::LIMIT_W-1:0]         cfg_data
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_ROTATE = 2'd1;
    localparam logic [1:0] ST_SERVE  = 2'd2;

    logic [1:0]                      state_reg, state_next;
    logic [ddq_pkg::LIMIT_W-1:0]     limit_reg, limit_next;
    logic [ddq_pkg::CNT_W-1:0]       u_occ_reg, u_occ_next;
    logic [ddq_pkg::CNT_W-1:0]       p_occ_reg, p_occ_next;
    logic [ddq_pkg::IDX_W-1:0]       p_head_reg, p_head_next;
    logic [ddq_pkg::TIME_W-1:0]      tick_reg, tick_next;
    logic [ddq_pkg::CNT_W-1:0]       scan_reg, scan_next;
    logic [ddq_pkg::CNT_W-1:0]       keep_reg, keep_next;
    logic                            found_reg, found_next;
    logic [ddq_pkg::IDX_W-1:0]       sel_idx_reg, sel_idx_next;
    ddq_pkg::ddq_entry_t             sel_entry_reg, sel_entry_next;
    logic                            out_valid_reg, out_valid_next;
    ddq_pkg::ddq_out_t               out_data_reg, out_data_next;

    logic                            out_free;
    logic                            in_accept;
    logic                            emit;
    logic                            urgent_ok;
    logic                            plain_ok;
    logic [ddq_pkg::CNT_W-1:0]       u_occ_m1;
    logic [ddq_pkg::SUM_W-1:0]       slot_sum;
    logic [ddq_pkg::IDX_W-1:0]       p_slot;
    logic [ddq_pkg::IDX_W-1:0]       p_head_inc;
    ddq_pkg::ddq_entry_t             serve_entry;
    logic [ddq_pkg::IDX_W-1:0]       serve_idx;

    logic                            shift_en;
    logic [ddq_pkg::IDX_W-1:0]       shift_from;
    logic                            load_en;
    logic [ddq_pkg::IDX_W-1:0]       load_idx;
    ddq_pkg::ddq_entry_t             load_data;
    ddq_pkg::ddq_cell_ctrl_t         cell_ctrl  [ddq_pkg::QUEUE_DEPTH];
    ddq_pkg::ddq_entry_t             cell_data  [ddq_pkg::QUEUE_DEPTH];
    ddq_pkg::ddq_entry_t             cell_right [ddq_pkg::QUEUE_DEPTH];
    ddq_pkg::ddq_eval_t              head_eval;

    logic                            ram_we;
    logic                            ram_re;
    ddq_pkg::ddq_plain_t             ram_wdata;
    ddq_pkg::ddq_plain_t             ram_rdata;

    // Urgent queue: row of cells, each shifting toward the head
    for (genvar i = 0; i < ddq_pkg::QUEUE_DEPTH; i++)
    begin : g_cell
        if (i == ddq_pkg::QUEUE_DEPTH - 1)
        begin : g_tail
            assign cell_right[i] = '0;
        end
        else
        begin : g_mid
            assign cell_right[i] = cell_data[i+1];
        end

        assign cell_ctrl[i].shift = shift_en && (ddq_pkg::IDX_W'(i) >= shift_from);
        assign cell_ctrl[i].load  = load_en && (ddq_pkg::IDX_W'(i) == load_idx);

        ddq_cell u_cell (
            .clk        (clk),
            .ctrl       (cell_ctrl[i]),
            .load_data  (load_data),
            .right_data (cell_right[i]),
            .data       (cell_data[i])
        );
    end

    ddq_head_eval u_head_eval (
        .entry (cell_data[0]),
        .now   (tick_reg),
        .eval  (head_eval)
    );

    ddq_ram #(
        .WIDTH ($bits(ddq_pkg::ddq_plain_t)),
        .DEPTH (ddq_pkg::QUEUE_DEPTH)
    ) u_plain_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (p_slot),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (p_head_reg),
        .rdata (ram_rdata)
    );

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = !((state_reg == ST_IDLE) && out_free);
    assign in_accept = in_valid && !in_stall;

    assign urgent_ok = (ddq_pkg::CMP_W'(u_occ_reg) < ddq_pkg::CMP_W'(limit_reg)) &&
                       (u_occ_reg < ddq_pkg::CNT_W'(ddq_pkg::QUEUE_DEPTH));
    assign plain_ok  = (ddq_pkg::CMP_W'(p_occ_reg) < ddq_pkg::CMP_W'(limit_reg)) &&
                       (p_occ_reg < ddq_pkg::CNT_W'(ddq_pkg::QUEUE_DEPTH));
    assign u_occ_m1  = u_occ_reg - 1'b1;

    // Plain tail slot, wrapped at the queue depth
    assign slot_sum   = ddq_pkg::SUM_W'(p_head_reg) + ddq_pkg::SUM_W'(p_occ_reg);
    assign p_slot     = (slot_sum >= ddq_pkg::SUM_W'(ddq_pkg::QUEUE_DEPTH)) ?
                        ddq_pkg::IDX_W'(slot_sum - ddq_pkg::SUM_W'(ddq_pkg::QUEUE_DEPTH)) :
                        ddq_pkg::IDX_W'(slot_sum);
    assign p_head_inc = (p_head_reg == ddq_pkg::IDX_W'(ddq_pkg::QUEUE_DEPTH - 1)) ?
                        '0 : p_head_reg + 1'b1;

    // A survivor with one tick left jumps the queue; otherwise the head goes
    assign serve_entry = found_reg ? sel_entry_reg : cell_data[0];
    assign serve_idx   = found_reg ? sel_idx_reg : '0;

    assign ram_wdata.tag   = ddq_pkg::tag_in(in_data.entry_tag);
    assign ram_wdata.stamp = tick_reg;

    always_comb
    begin
        state_next     = state_reg;
        limit_next     = limit_reg;
        u_occ_next     = u_occ_reg;
        p_occ_next     = p_occ_reg;
        p_head_next    = p_head_reg;
        tick_next      = tick_reg;
        scan_next      = scan_reg;
        keep_next      = keep_reg;
        found_next     = found_reg;
        sel_idx_next   = sel_idx_reg;
        sel_entry_next = sel_entry_reg;
        out_data_next  = out_data_reg;
        emit           = 1'b0;
        shift_en       = 1'b0;
        shift_from     = '0;
        load_en        = 1'b0;
        load_idx       = '0;
        load_data      = cell_data[0];
        ram_we         = 1'b0;
        ram_re         = 1'b0;

        if (cfg_we)
        begin
            limit_next = cfg_data;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    unique case (in_data.command)
                        ddq_pkg::CMD_URGENT:
                        begin
                            emit                     = 1'b1;
                            out_data_next.event_res  = ddq_pkg::EV_REFUSED;
                            out_data_next.result_tag =
                                ddq_pkg::tag_out(ddq_pkg::tag_in(in_data.entry_tag));
                            out_data_next.waited     = '0;
                            out_data_next.last       = 1'b1;
                            if (urgent_ok)
                            begin
                                load_en                 = 1'b1;
                                load_idx                = u_occ_reg[ddq_pkg::IDX_W-1:0];
                                load_data.tag           = ddq_pkg::tag_in(in_data.entry_tag);
                                load_data.stamp         = tick_reg;
                                load_data.budget        = in_data.budget;
                                u_occ_next              = u_occ_reg + 1'b1;
                                out_data_next.event_res = ddq_pkg::EV_ACCEPTED;
                            end
                        end
                        ddq_pkg::CMD_PLAIN:
                        begin
                            emit                     = 1'b1;
                            out_data_next.event_res  = ddq_pkg::EV_REFUSED;
                            out_data_next.result_tag =
                                ddq_pkg::tag_out(ddq_pkg::tag_in(in_data.entry_tag));
                            out_data_next.waited     = '0;
                            out_data_next.last       = 1'b1;
                            if (plain_ok)
                            begin
                                ram_we                  = 1'b1;
                                p_occ_next              = p_occ_reg + 1'b1;
                                out_data_next.event_res = ddq_pkg::EV_ACCEPTED;
                            end
                        end
                        ddq_pkg::CMD_TICK:
                        begin
                            // Fetch the plain head now; the RAM holds it until serve
                            ram_re     = 1'b1;
                            scan_next  = u_occ_reg;
                            keep_next  = '0;
                            found_next = 1'b0;
                            state_next = ST_ROTATE;
                        end
                        default:
                        begin
                            // drop unknown commands
                        end
                    endcase
                end
            end
            ST_ROTATE:
            begin
                if (scan_reg == '0)
                begin
                    state_next = ST_SERVE;
                end
                else if (head_eval.expired)
                begin
                    if (out_free)
                    begin
                        emit                     = 1'b1;
                        out_data_next.event_res  = ddq_pkg::EV_EXPIRED;
                        out_data_next.result_tag = ddq_pkg::tag_out(cell_data[0].tag);
                        out_data_next.waited     = head_eval.waited;
                        out_data_next.last       = 1'b0;
                        shift_en                 = 1'b1;
                        u_occ_next               = u_occ_m1;
                        scan_next                = scan_reg - 1'b1;
                    end
                end
                else
                begin
                    // Recirculate the head entry to the tail
                    shift_en  = 1'b1;
                    load_en   = 1'b1;
                    load_idx  = u_occ_m1[ddq_pkg::IDX_W-1:0];
                    load_data = cell_data[0];
                    if (head_eval.rem_one && !found_reg)
                    begin
                        found_next     = 1'b1;
                        sel_idx_next   = keep_reg[ddq_pkg::IDX_W-1:0];
                        sel_entry_next = cell_data[0];
                    end
                    keep_next = keep_reg + 1'b1;
                    scan_next = scan_reg - 1'b1;
                end
            end
            ST_SERVE:
            begin
                if (out_free)
                begin
                    emit               = 1'b1;
                    out_data_next.last = 1'b1;
                    tick_next          = tick_reg + 1'b1;
                    state_next         = ST_IDLE;
                    if (u_occ_reg != '0)
                    begin
                        shift_en                 = 1'b1;
                        shift_from               = serve_idx;
                        u_occ_next               = u_occ_m1;
                        out_data_next.event_res  = ddq_pkg::EV_URGENT;
                        out_data_next.result_tag = ddq_pkg::tag_out(serve_entry.tag);
                        out_data_next.waited     = ddq_pkg::sat_wait(tick_reg,
                                                                     serve_entry.stamp);
                    end
                    else if (p_occ_reg != '0)
                    begin
                        p_head_next              = p_head_inc;
                        p_occ_next               = p_occ_reg - 1'b1;
                        out_data_next.event_res  = ddq_pkg::EV_PLAIN;
                        out_data_next.result_tag = ddq_pkg::tag_out(ram_rdata.tag);
                        out_data_next.waited     = ddq_pkg::sat_wait(tick_reg,
                                                                     ram_rdata.stamp);
                    end
                    else
                    begin
                        out_data_next.event_res  = ddq_pkg::EV_IDLE;
                        out_data_next.result_tag = '0;
                        out_data_next.waited     = '0;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (emit)
        begin
            out_data_next.urgent_count = ddq_pkg::PCNT_W'(u_occ_next);
            out_data_next.plain_count  = ddq_pkg::PCNT_W'(p_occ_next);
        end

        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            limit_reg     <= ddq_pkg::LIMIT_RESET;
            u_occ_reg     <= '0;
            p_occ_reg     <= '0;
            p_head_reg    <= '0;
            tick_reg      <= '0;
            scan_reg      <= '0;
            keep_reg      <= '0;
            found_reg     <= 1'b0;
            sel_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            limit_reg     <= limit_next;
            u_occ_reg     <= u_occ_next;
            p_occ_reg     <= p_occ_next;
            p_head_reg    <= p_head_next;
            tick_reg      <= tick_next;
            scan_reg      <= scan_next;
            keep_reg      <= keep_next;
            found_reg     <= found_next;
            sel_idx_reg   <= sel_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sel_entry_reg <= sel_entry_next;
        out_data_reg  <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Every urgent entry is either still to be walked or already recirculated
    a_rotate_balance: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROTATE) |->
            (u_occ_reg == ddq_pkg::CNT_W'(scan_reg + keep_reg)))
        else $error("urgent occupancy out of step with the walk");

    a_sel_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg != ST_IDLE) && found_reg) |->
            (ddq_pkg::CNT_W'(sel_idx_reg) < keep_reg))
        else $error("selected urgent entry beyond the survivors");

    a_tick_advance: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_SERVE) && out_free) |=>
            ((tick_reg == $past(tick_reg) + 32'd1) && (state_reg == ST_IDLE)))
        else $error("tick counter did not advance on serve");

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (u_occ_reg <= ddq_pkg::CNT_W'(ddq_pkg::QUEUE_DEPTH)) &&
        (p_occ_reg <= ddq_pkg::CNT_W'(ddq_pkg::QUEUE_DEPTH)))
        else $error("queue occupancy above depth");

endmodule
